// ===== design/fdec_pkg.sv =====
// ----------------------------------------------------------------------------
// fdec_pkg
// Shared sizes, action codes, control struct and helpers of the decimating FIR.
// ----------------------------------------------------------------------------
package fdec_pkg;

    localparam int TAPS_PER_PHASE = 16;
    localparam int MAX_FACTOR     = 16;
    localparam int SAMPLE_WIDTH   = 24;

    localparam int HIST_LEN = TAPS_PER_PHASE * MAX_FACTOR;
    localparam int HA_W     = $clog2(HIST_LEN);
    localparam int LOG2_MAX = $clog2(MAX_FACTOR + 1) - 1;
    localparam int PH_W     = (LOG2_MAX > 0) ? LOG2_MAX : 1;
    localparam int FACT_W   = 3;
    localparam int CIX_W    = 8;
    localparam int ACT_W    = 2;
    localparam int FRAC     = SAMPLE_WIDTH - 1;
    localparam int ACC_W    = 2 * SAMPLE_WIDTH + HA_W;
    localparam int SH_W     = ACC_W - FRAC;

    localparam logic [ACC_W-1:0] RND_HALF = {{(ACC_W-1){1'b0}}, 1'b1} << (FRAC - 1);

    typedef enum logic [ACT_W-1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_COEFF  = 2'd1,
        ACT_CLEAR  = 2'd2
    } t_action;

    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } t_mac_ctl;

    function automatic logic [FACT_W-1:0] eff_log2(input logic [FACT_W-1:0] f);
        if (32'(f) > LOG2_MAX) begin
            return FACT_W'(LOG2_MAX);
        end
        return f;
    endfunction

    function automatic logic [HA_W-1:0] tap_last(input logic [FACT_W-1:0] lg);
        int t;
        t = TAPS_PER_PHASE << lg;
        if (t > HIST_LEN) begin
            t = HIST_LEN;
        end
        return HA_W'(t - 1);
    endfunction

    // half-LSB round, floor, saturate to the sample range
    function automatic logic [SAMPLE_WIDTH-1:0] round_sat(input logic [ACC_W-1:0] acc);
        logic [ACC_W-1:0] u;
        logic [SH_W-1:0]  sh;
        logic [SAMPLE_WIDTH-1:0] res;
        u  = acc + RND_HALF;
        sh = u[ACC_W-1:FRAC];
        if (!sh[SH_W-1] && (|sh[SH_W-2:SAMPLE_WIDTH-1])) begin
            res = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end else if (sh[SH_W-1] && !(&sh[SH_W-2:SAMPLE_WIDTH-1])) begin
            res = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end else begin
            res = sh[SAMPLE_WIDTH-1:0];
        end
        return res;
    endfunction

endpackage

// ===== design/fdec_ram.sv =====
// ----------------------------------------------------------------------------
// fdec_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fdec_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/fdec_mac.sv =====
// ----------------------------------------------------------------------------
// fdec_mac
// Registered multiply followed by a wide accumulator; rounds the final sum.
// ----------------------------------------------------------------------------
module fdec_mac (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  fdec_pkg::t_mac_ctl                     i_ctl,
    input  logic signed [fdec_pkg::SAMPLE_WIDTH-1:0] i_coef,
    input  logic signed [fdec_pkg::SAMPLE_WIDTH-1:0] i_hist,
    output logic                                   o_done,
    output logic [fdec_pkg::SAMPLE_WIDTH-1:0]      o_result
);
    import fdec_pkg::*;

    logic signed [2*SAMPLE_WIDTH-1:0] r_prod;
    logic                             r_pv;
    logic                             r_pfirst;
    logic                             r_plast;
    logic                             r_done;
    logic [ACC_W-1:0]                 r_acc;
    logic [ACC_W-1:0]                 n_acc;

    assign n_acc = (r_pfirst ? '0 : r_acc) + {{HA_W{r_prod[2*SAMPLE_WIDTH-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv     <= 1'b0;
            r_pfirst <= 1'b0;
            r_plast  <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_pv     <= i_ctl.vld;
            r_pfirst <= i_ctl.first;
            r_plast  <= i_ctl.last;
            r_done   <= r_pv & r_plast;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_coef * i_hist;
        if (r_pv) begin
            r_acc <= n_acc;
        end
    end

    assign o_done   = r_done;
    assign o_result = round_sat(r_acc);

endmodule

// ===== design/fir_decimator.sv =====
// ----------------------------------------------------------------------------
// fir_decimator
// Decimating FIR filter, Q1.23 samples and coefficients.
//
// Input channel (i_valid / o_stall) carries one word per item: an audio
// sample, a coefficient load (tap index and value) or a history clear.
// Output channel (o_valid / i_stall) carries one filtered sample per word.
// i_cfg_wr_en / i_cfg_wr_data set log2 of the decimation factor (clamped to
// log2 of the largest factor) and clear the phase; write only while idle.
//
// Coefficient loads, clears and samples that do not close a phase are taken
// while idle. The sample that closes a phase runs one multiply-accumulate per
// cycle over TAPS_PER_PHASE << factor_log2 taps, reading the coefficient
// RAM and the history RAM once per tap; no further item is taken until the
// result has passed the drain and hold states into the output register.
// With factor 1 a sample passes to the output register and appears the next cycle.
// Reset empties the history (per-entry valid flags), the write position,
// phase and factor; coefficients must be loaded before use. While the
// receiver stalls, the result holds in the output register and further items
// are taken until another result needs that register.
// ----------------------------------------------------------------------------
module fir_decimator (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_stall,
    input  logic [fdec_pkg::ACT_W-1:0]               i_action,
    input  logic signed [fdec_pkg::SAMPLE_WIDTH-1:0] i_sample,
    input  logic [fdec_pkg::CIX_W-1:0]               i_coeff_index,
    input  logic signed [fdec_pkg::SAMPLE_WIDTH-1:0] i_coeff_value,
    output logic                                     o_valid,
    input  logic                                     i_stall,
    output logic signed [fdec_pkg::SAMPLE_WIDTH-1:0] o_out_sample,
    input  logic                                     i_cfg_wr_en,
    input  logic [fdec_pkg::FACT_W-1:0]              i_cfg_wr_data
);
    import fdec_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MAC   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_HOLD  = 4'b1000
    } t_state;

    t_state                  r_state;
    t_state                  n_state;
    logic [FACT_W-1:0]       r_factor;
    logic [PH_W-1:0]         r_phase;
    logic [HA_W-1:0]         r_wp;
    logic [HA_W-1:0]         r_rp;
    logic [HA_W-1:0]         r_tap;
    logic [HIST_LEN-1:0]     r_hvalid;
    logic                    r_hv_q;
    t_mac_ctl                r_ctl;
    logic                    r_out_valid;
    logic [SAMPLE_WIDTH-1:0] r_out_sample;

    logic [FACT_W-1:0]       eff;
    logic [HA_W-1:0]         tap_end;
    logic                    pass;
    logic                    in_acc;
    logic                    is_sample;
    logic                    is_clear;
    logic                    hist_we;
    logic                    coef_we;
    logic [31:0]             cix_ext;
    logic [PH_W:0]           phase_nx;
    logic [PH_W:0]           factor;
    logic                    phase_wrap;
    logic                    start;
    logic [HA_W-1:0]         wp_inc;
    logic [HA_W-1:0]         rp_dec;
    logic                    issue;
    logic                    out_free;
    logic [SAMPLE_WIDTH-1:0] coef_rd;
    logic [SAMPLE_WIDTH-1:0] hist_rd;
    logic [SAMPLE_WIDTH-1:0] hist_q;
    logic                    mac_done;
    logic [SAMPLE_WIDTH-1:0] mac_result;

    assign eff        = eff_log2(r_factor);
    assign tap_end    = tap_last(eff);
    assign pass       = (eff == '0);
    assign out_free   = !r_out_valid || !i_stall;
    assign o_stall    = (r_state != S_IDLE)
                      || ((i_action == ACT_SAMPLE) && pass && !out_free);
    assign in_acc     = i_valid && !o_stall;
    assign is_sample  = in_acc && (i_action == ACT_SAMPLE);
    assign is_clear   = in_acc && (i_action == ACT_CLEAR);
    assign hist_we    = is_sample && !pass;
    assign cix_ext    = 32'(i_coeff_index);
    assign coef_we    = in_acc && (i_action == ACT_COEFF) && (cix_ext < HIST_LEN);
    assign phase_nx   = {1'b0, r_phase} + (PH_W+1)'(1);
    assign factor     = (PH_W+1)'(1) << eff;
    assign phase_wrap = (phase_nx == factor);
    assign start      = hist_we && phase_wrap;
    assign wp_inc     = (r_wp == HA_W'(HIST_LEN - 1)) ? '0 : r_wp + HA_W'(1);
    assign rp_dec     = (r_rp == '0) ? HA_W'(HIST_LEN - 1) : r_rp - HA_W'(1);
    assign issue      = (r_state == S_MAC);
    assign hist_q     = r_hv_q ? hist_rd : '0;

    fdec_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (HIST_LEN)
    ) u_coef_ram (
        .i_clk     (i_clk),
        .i_wr_en   (coef_we),
        .i_wr_addr (cix_ext[HA_W-1:0]),
        .i_wr_data (i_coeff_value),
        .i_rd_en   (issue),
        .i_rd_addr (r_tap),
        .o_rd_data (coef_rd)
    );

    fdec_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (HIST_LEN)
    ) u_hist_ram (
        .i_clk     (i_clk),
        .i_wr_en   (hist_we),
        .i_wr_addr (r_wp),
        .i_wr_data (i_sample),
        .i_rd_en   (issue),
        .i_rd_addr (r_rp),
        .o_rd_data (hist_rd)
    );

    fdec_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_ctl),
        .i_coef   (coef_rd),
        .i_hist   (hist_q),
        .o_done   (mac_done),
        .o_result (mac_result)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                if (r_tap == tap_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (mac_done) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_factor    <= '0;
            r_phase     <= '0;
            r_wp        <= '0;
            r_rp        <= '0;
            r_tap       <= '0;
            r_hvalid    <= '0;
            r_ctl       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_wr_en) begin
                r_factor <= i_cfg_wr_data;
                r_phase  <= '0;
            end else if (is_clear) begin
                r_phase <= '0;
            end else if (hist_we) begin
                r_phase <= phase_wrap ? '0 : phase_nx[PH_W-1:0];
            end

            if (is_clear) begin
                r_wp     <= '0;
                r_hvalid <= '0;
            end else if (hist_we) begin
                r_wp           <= wp_inc;
                r_hvalid[r_wp] <= 1'b1;
            end

            if (start) begin
                r_rp  <= r_wp;
                r_tap <= '0;
            end else if (issue) begin
                r_rp  <= rp_dec;
                r_tap <= r_tap + HA_W'(1);
            end

            r_ctl.vld   <= issue;
            r_ctl.first <= issue && (r_tap == '0);
            r_ctl.last  <= issue && (r_tap == tap_end);

            if ((r_state == S_HOLD) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (is_sample && pass) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hv_q <= r_hvalid[r_rp];
        if ((r_state == S_HOLD) && out_free) begin
            r_out_sample <= mac_result;
        end else if (is_sample && pass) begin
            r_out_sample <= i_sample;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_sample = r_out_sample;

    a_done_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_done |-> (r_state == S_DRAIN))
        else $error("accumulator finished outside drain");

    a_phase_below_factor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_phase} < factor))
        else $error("phase count reached the factor");

    a_tap_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_tap <= tap_end))
        else $error("tap counter ran past the last tap");

    a_hold_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_HOLD) && out_free) |=> ((r_state == S_IDLE) && o_valid))
        else $error("result not loaded when output register was free");

    a_hist_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hist_we |-> (r_state == S_IDLE))
        else $error("history written during a filter pass");

endmodule
